@@ sv/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KFEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define KFEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/kfec_pkg.sv @@
// Types and codes for the keyed FIFO-eviction cache.
`timescale 1ns / 1ps
package kfec_pkg;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [5:0]         coll_kind;
    logic [7:0]         algo_variant;
    logic signed [31:0] root_rank;
    logic signed [31:0] key_param;
    logic [31:0]        new_handle;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_handle;
    logic        evicted;
    logic [31:0] evicted_handle;
  } rsp_t;

  typedef struct packed {
    logic [5:0]         coll_kind;
    logic [7:0]         algo_variant;
    logic signed [31:0] root_rank;
    logic signed [31:0] key_param;
  } key_t;

  // Per-cell control from the fill logic.
  typedef struct packed {
    logic valid;
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Match carry passed from older to newer cells.
  typedef struct packed {
    logic        hit;
    logic [31:0] handle;
  } match_t;

endpackage

@@ sv/keyed_fifo_evict_cache_unit.sv @@
// Top level: chain of entry cells, fill count and registered response word.
// Response: the response word is registered when the request is accepted.
// Throughput: 1 request per cycle while the response word is taken; the lookup match ripples through the cell chain.
// Reset: fill count and response valid clear; entry contents are left as is.
`timescale 1ns / 1ps
module keyed_fifo_evict_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  kfec_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output kfec_pkg::rsp_t  rsp
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [CNT_W-1:0]     fill_count;
  logic [CNT_W-1:0]     fill_count_next;
  logic                 accept;
  logic                 is_ins;
  logic                 full;
  logic                 evict;
  kfec_pkg::key_t       req_key;
  kfec_pkg::key_t       cell_key    [ENTRIES];
  logic [31:0]          cell_handle [ENTRIES];
  kfec_pkg::key_t       up_key      [ENTRIES];
  logic [31:0]          up_handle   [ENTRIES];
  kfec_pkg::cell_ctrl_t cell_ctrl   [ENTRIES];
  kfec_pkg::match_t     chain       [ENTRIES+1];
  kfec_pkg::rsp_t       rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign is_ins    = (req.op == kfec_pkg::OP_INSERT);
  assign full      = (fill_count == CNT_W'(ENTRIES));
  assign evict     = accept && is_ins && full;

  assign req_key.coll_kind    = req.coll_kind;
  assign req_key.algo_variant = req.algo_variant;
  assign req_key.root_rank    = req.root_rank;
  assign req_key.key_param    = req.key_param;

  assign chain[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    always_comb begin
      cell_ctrl[i].valid = (fill_count > CNT_W'(i));
      cell_ctrl[i].shift = evict;
      if (full) begin
        cell_ctrl[i].load = accept && is_ins && (i == ENTRIES - 1);
      end else begin
        cell_ctrl[i].load = accept && is_ins && (fill_count == CNT_W'(i));
      end
    end

    if (i == ENTRIES - 1) begin : g_last
      assign up_key[i]    = req_key;
      assign up_handle[i] = req.new_handle;
    end else begin : g_mid
      assign up_key[i]    = cell_key[i+1];
      assign up_handle[i] = cell_handle[i+1];
    end

    kfec_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .new_key    (req_key),
      .new_handle (req.new_handle),
      .up_key     (up_key[i]),
      .up_handle  (up_handle[i]),
      .carry_in   (chain[i]),
      .key        (cell_key[i]),
      .handle     (cell_handle[i]),
      .carry_out  (chain[i+1])
    );
  end

  always_comb begin
    fill_count_next = fill_count;
    if (accept && is_ins && !full) begin
      fill_count_next = fill_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  always_comb begin
    rsp_next.hit            = !is_ins && chain[ENTRIES].hit;
    rsp_next.found_handle   = rsp_next.hit ? chain[ENTRIES].handle : 32'd0;
    rsp_next.evicted        = is_ins && full;
    rsp_next.evicted_handle = rsp_next.evicted ? cell_handle[0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ sv/kfec_cell.sv @@
// One cache entry: stored key and handle, key compare, match carry and shift.
`timescale 1ns / 1ps
module kfec_cell (
  input  logic                clk,
  input  kfec_pkg::cell_ctrl_t ctrl,
  input  kfec_pkg::key_t      new_key,
  input  logic [31:0]         new_handle,
  input  kfec_pkg::key_t      up_key,
  input  logic [31:0]         up_handle,
  input  kfec_pkg::match_t    carry_in,
  output kfec_pkg::key_t      key,
  output logic [31:0]         handle,
  output kfec_pkg::match_t    carry_out
);

  kfec_pkg::key_t key_next;
  logic [31:0]    handle_next;
  logic           match;

  always_comb begin
    if (ctrl.load) begin
      key_next    = new_key;
      handle_next = new_handle;
    end else if (ctrl.shift) begin
      key_next    = up_key;
      handle_next = up_handle;
    end else begin
      key_next    = key;
      handle_next = handle;
    end
  end

  always_ff @(posedge clk) begin
    key    <= key_next;
    handle <= handle_next;
  end

  assign match = ctrl.valid && (key == new_key);

  // Older entry wins.
  always_comb begin
    if (carry_in.hit) begin
      carry_out = carry_in;
    end else begin
      carry_out.hit    = match;
      carry_out.handle = handle;
    end
  end

endmodule

@@ sv/kfec_checker.sv @@
// Port-level checker for the keyed FIFO-eviction cache, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kfec_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input kfec_pkg::rsp_t rsp
);

  logic req_fire;

  assign req_fire = req_valid && req_ready;

  `KFEC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `KFEC_ASSERT_NEXT(a_req_gives_rsp, req_fire, rsp_valid)
  `KFEC_ASSERT_NOW(a_hit_xor_evict, rsp_valid, !(rsp.hit && rsp.evicted))
  `KFEC_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp.hit, rsp.found_handle == 32'd0)
  `KFEC_ASSERT_NOW(a_noevict_zero, rsp_valid && !rsp.evicted, rsp.evicted_handle == 32'd0)

endmodule

bind keyed_fifo_evict_cache_unit kfec_checker u_kfec_checker (.*);

@@ verif/tb_keyed_fifo_evict_cache_unit.sv @@
// Testbench for the keyed FIFO-eviction cache: directed rows, then random words.
`timescale 1ns / 1ps
module tb_keyed_fifo_evict_cache_unit;

  localparam int CACHE_DEPTH = 16;
  localparam int KEY_POOL    = 20;
  localparam int RAND_WORDS  = 1500;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 10;

  typedef struct {
    kfec_pkg::req_t word;
    bit             typed;
    kfec_pkg::rsp_t rsp;
  } stim_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  kfec_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  kfec_pkg::rsp_t rsp;

  // cache image held by the predictor
  kfec_pkg::key_t cached_keys[CACHE_DEPTH];
  logic [31:0]    cached_handles[CACHE_DEPTH];
  int             cached_count;

  kfec_pkg::rsp_t pending_rsp[$];
  stim_row_t      dir_rows[$];
  kfec_pkg::key_t key_pool[KEY_POOL];
  int             err_cnt;
  int             burst_left;
  bit             hold_go;
  bit             cur_typed;
  kfec_pkg::rsp_t cur_expect;

  keyed_fifo_evict_cache_unit #(.ENTRIES(CACHE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_keyed_fifo_evict_cache_unit: done, errors");
    $finish;
  end

  function automatic kfec_pkg::rsp_t cache_access(kfec_pkg::req_t r);
    kfec_pkg::rsp_t res;
    kfec_pkg::key_t k;
    res = '0;
    k.coll_kind    = r.coll_kind;
    k.algo_variant = r.algo_variant;
    k.root_rank    = r.root_rank;
    k.key_param    = r.key_param;
    if (r.op == kfec_pkg::OP_LOOKUP) begin
      // scan newest to oldest so the oldest match wins
      for (int i = cached_count - 1; i >= 0; i--) begin
        if (cached_keys[i] == k) begin
          res.hit          = 1'b1;
          res.found_handle = cached_handles[i];
        end
      end
    end else begin
      if (cached_count == CACHE_DEPTH) begin
        res.evicted        = 1'b1;
        res.evicted_handle = cached_handles[0];
        for (int i = 1; i < CACHE_DEPTH; i++) begin
          cached_keys[i - 1]    = cached_keys[i];
          cached_handles[i - 1] = cached_handles[i];
        end
        cached_count--;
      end
      cached_keys[cached_count]    = k;
      cached_handles[cached_count] = r.new_handle;
      cached_count++;
    end
    return res;
  endfunction

  function automatic kfec_pkg::req_t mk_req(kfec_pkg::op_t o, logic [5:0] ck, logic [7:0] av,
                                            logic [31:0] rr, logic [31:0] kp,
                                            logic [31:0] nh);
    kfec_pkg::req_t r;
    r.op           = o;
    r.coll_kind    = ck;
    r.algo_variant = av;
    r.root_rank    = rr;
    r.key_param    = kp;
    r.new_handle   = nh;
    return r;
  endfunction

  function automatic kfec_pkg::rsp_t rsp_of(logic h, logic [31:0] fh, logic ev,
                                            logic [31:0] eh);
    kfec_pkg::rsp_t e;
    e.hit            = h;
    e.found_handle   = fh;
    e.evicted        = ev;
    e.evicted_handle = eh;
    return e;
  endfunction

  function automatic void add_row(kfec_pkg::req_t r, bit tp, kfec_pkg::rsp_t e);
    stim_row_t s;
    s.word  = r;
    s.typed = tp;
    s.rsp   = e;
    dir_rows.push_back(s);
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 3))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  function automatic void build_pool();
    for (int i = 0; i < KEY_POOL; i++) begin
      if (i % 2 == 1) begin
        // near miss: differs from its neighbor in one field
        key_pool[i] = key_pool[i - 1];
        case ($urandom_range(0, 3))
          0: key_pool[i].coll_kind = key_pool[i].coll_kind ^ 6'h01;
          1: key_pool[i].algo_variant = key_pool[i].algo_variant ^ 8'h80;
          2: key_pool[i].root_rank =
               key_pool[i].root_rank ^ (32'h1 << $urandom_range(0, 31));
          default: key_pool[i].key_param =
                     key_pool[i].key_param ^ (32'h1 << $urandom_range(0, 31));
        endcase
      end else begin
        key_pool[i].coll_kind    = 6'($urandom);
        key_pool[i].algo_variant = 8'($urandom);
        key_pool[i].root_rank    = $urandom;
        key_pool[i].key_param    = $urandom;
      end
    end
  endfunction

  function automatic kfec_pkg::req_t rand_req();
    kfec_pkg::req_t r;
    kfec_pkg::key_t k;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      k = key_pool[$urandom_range(0, KEY_POOL - 1)];
    end else if (pick < 90) begin
      k.coll_kind    = 6'($urandom);
      k.algo_variant = 8'($urandom);
      k.root_rank    = $urandom;
      k.key_param    = $urandom;
    end else begin
      k.coll_kind    = $urandom_range(0, 1) ? 6'h3F : 6'h00;
      k.algo_variant = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      k.root_rank    = corner_word();
      k.key_param    = corner_word();
    end
    r = mk_req(($urandom_range(0, 99) < 55) ? kfec_pkg::OP_LOOKUP : kfec_pkg::OP_INSERT,
               k.coll_kind, k.algo_variant, k.root_rank, k.key_param,
               ($urandom_range(0, 15) == 0) ? 32'h0 : 32'($urandom));
    return r;
  endfunction

  // called just after a falling edge; returns just after the falling edge that follows acceptance
  task automatic offer_word(kfec_pkg::req_t r, bit tp, kfec_pkg::rsp_t e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    req_valid  = 1'b1;
    req        = r;
    cur_typed  = tp;
    cur_expect = e;
    do @(posedge clk); while (!req_ready);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain_pending();
    req_valid  = 1'b0;
    burst_left = 0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : check
    kfec_pkg::rsp_t want;
    kfec_pkg::rsp_t predicted;
    if (!rst) begin
      if (req_valid && req_ready) begin
        predicted = cache_access(req);
        pending_rsp.push_back(cur_typed ? cur_expect : predicted);
      end
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $error("response word with nothing expected");
          err_cnt++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            err_cnt++;
          end
          if (rsp.found_handle !== want.found_handle) begin
            $error("found_handle: expected %h, got %h", want.found_handle, rsp.found_handle);
            err_cnt++;
          end
          if (rsp.evicted !== want.evicted) begin
            $error("evicted: expected %0d, got %0d", want.evicted, rsp.evicted);
            err_cnt++;
          end
          if (rsp.evicted_handle !== want.evicted_handle) begin
            $error("evicted_handle: expected %h, got %h", want.evicted_handle,
                   rsp.evicted_handle);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int mode;
    int span;
    rsp_ready = 1'b0;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 96);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        if (hold_go) begin
          hold_go   = 1'b0;
          rsp_ready = 1'b0;
          for (int h = 0; h < HOLD_CYCLES; h++) @(negedge clk);
        end
        case (mode)
          0:       rsp_ready = 1'b1;
          1:       rsp_ready = 1'($urandom_range(0, 1));
          2:       rsp_ready = ($urandom_range(0, 7) != 0);
          default: rsp_ready = (c % 3 == 0);
        endcase
      end
    end
  end

  initial begin : sender
    int n;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    cur_typed    = 1'b0;
    cur_expect   = '0;
    hold_go      = 1'b0;
    err_cnt      = 0;
    burst_left   = 0;
    cached_count = 0;
    build_pool();

    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
            rsp_of(1'b0, 32'h0, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_INSERT, 6'h3F, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'hFFFF_FFFF), 1'b1, rsp_of(1'b0, 32'h0, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_INSERT, 6'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
            rsp_of(1'b0, 32'h0, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h00, 8'h00, 32'h0, 32'h0, 32'h5555_5555), 1'b1,
            rsp_of(1'b1, 32'h0, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h3F, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0),
            1'b1, rsp_of(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0));
    // duplicate key: the older entry keeps answering
    add_row(mk_req(kfec_pkg::OP_INSERT, 6'h3F, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h1234_5678), 1'b1, rsp_of(1'b0, 32'h0, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h3F, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0),
            1'b1, rsp_of(1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h00, 8'h00, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'hAAAA_AAAA), 1'b1, rsp_of(1'b0, 32'h0, 1'b0, 32'h0));
    for (int i = 0; i < CACHE_DEPTH - 3; i++)
      add_row(mk_req(kfec_pkg::OP_INSERT, 6'(i + 1), 8'(8'h80 | i), 32'(i * 32'h0101_0101),
                     32'(-(i + 1)), 32'(32'h100 + i)), 1'b0, '0);
    add_row(mk_req(kfec_pkg::OP_INSERT, 6'h00, 8'h00, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hA5A5_A5A5), 1'b1, rsp_of(1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h3F, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0),
            1'b0, '0);
    add_row(mk_req(kfec_pkg::OP_INSERT, 6'h00, 8'h00, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                   32'hDEAD_BEEF), 1'b1, rsp_of(1'b0, 32'h0, 1'b1, 32'h0));
    add_row(mk_req(kfec_pkg::OP_LOOKUP, 6'h00, 8'h00, 32'h0, 32'h0, 32'h0), 1'b1,
            rsp_of(1'b0, 32'h0, 1'b0, 32'h0));

    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].rsp);
    drain_pending();

    for (n = 0; n < RAND_WORDS; n++) begin
      if (n == 400) hold_go = 1'b1;
      if (n == 900) drain_pending();
      offer_word(rand_req(), 1'b0, '0);
    end
    req_valid = 1'b0;

    for (int k = 0; k < DRAIN_LIMIT && pending_rsp.size() != 0; k++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      $error("%0d response words never arrived", pending_rsp.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("tb_keyed_fifo_evict_cache_unit: done, clean");
    end else begin
      $display("tb_keyed_fifo_evict_cache_unit: done, errors");
    end
    $finish;
  end

endmodule
